### rtl/core/rmsprop_element_update_unit_defines.svh
// assertion helpers for the rmsprop core
`ifndef RMSPROP_ELEMENT_UPDATE_UNIT_DEFINES_SVH
`define RMSPROP_ELEMENT_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication
`define RMSP_ASSERT_IMPL(name, clk, rst, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("rmsp assertion failed");

// next-cycle implication
`define RMSP_ASSERT_NEXT(name, clk, rst, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("rmsp assertion failed");

`endif

### rtl/core/rmsp_pkg.sv
`timescale 1ns / 1ps
package rmsp_pkg;

  localparam int ELEMENT_COUNT_DEF = 4096;
  localparam int IDX_W = 12;
  localparam int IDX_SPAN = 1 << IDX_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] ALPHA_RESET = 16'd64881;
  localparam logic [15:0] EPS_RESET = 16'd1;
  localparam logic [16:0] ONE_Q16 = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_EN    = 3'd0,
    CFG_DECAY_COEFF = 3'd1,
    CFG_MOM_EN      = 3'd2,
    CFG_MOM_COEFF   = 3'd3,
    CFG_ALPHA       = 3'd4,
    CFG_EPSILON     = 3'd5,
    CFG_CENTERED    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        decay_enable;
    logic [15:0] decay_coeff;
    logic        momentum_enable;
    logic [15:0] momentum_coeff;
    logic [15:0] smoothing_alpha;
    logic [15:0] epsilon;
    logic        centered_mode;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] gradient;
    logic signed [31:0] weight;
    logic [15:0]        learning_rate;
  } item_t;

  // round half up, then drop 16 fraction bits
  function automatic logic signed [51:0] rnd16(input logic signed [67:0] x);
    logic signed [67:0] t;
    t = (x + 68'sd32768) >>> 16;
    return t[51:0];
  endfunction

  // {flag, value}
  function automatic logic [32:0] sat32(input logic signed [67:0] x);
    if (x > 68'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (x < -68'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, x[31:0]};
  endfunction

endpackage

### rtl/core/rmsp_in_if.sv
`timescale 1ns / 1ps
interface rmsp_in_if;
  logic               valid;
  logic               ready;
  logic [11:0]        elem_index;
  logic signed [31:0] gradient;
  logic signed [31:0] weight;
  logic [15:0]        learning_rate;

  modport source (output valid, elem_index, gradient, weight, learning_rate, input ready);
  modport sink (input valid, elem_index, gradient, weight, learning_rate, output ready);
endinterface

### rtl/core/rmsp_out_if.sv
`timescale 1ns / 1ps
interface rmsp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_weight;
  logic               saturated;

  modport source (output valid, new_weight, saturated, input ready);
  modport sink (input valid, new_weight, saturated, output ready);
endinterface

### rtl/core/rmsp_front.sv
`timescale 1ns / 1ps
module rmsp_front #(
  parameter int ELEMENT_COUNT = rmsp_pkg::ELEMENT_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  rmsp_in_if.sink         req,
  output rmsp_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_ready
);

  localparam int MOD_INT = ELEMENT_COUNT > rmsp_pkg::IDX_SPAN ?
                           rmsp_pkg::IDX_SPAN : ELEMENT_COUNT;
  localparam logic [rmsp_pkg::IDX_W:0] MODN = (rmsp_pkg::IDX_W+1)'(MOD_INT);
  localparam int RECIP = (1 << 24) / MOD_INT;
  localparam logic [24:0] RECIP_C = 25'(RECIP);

  logic [36:0]                idx_prod;
  logic [rmsp_pkg::IDX_W:0]   idx_quo;
  logic [25:0]                quo_prod;
  logic [rmsp_pkg::IDX_W:0]   idx_rem;
  logic [rmsp_pkg::IDX_W-1:0] idx_red;

  assign req.ready = !item_valid;

  // index wrap by reciprocal multiply and one correction
  always_comb begin
    idx_prod = {25'd0, req.elem_index} * {12'd0, RECIP_C};
    idx_quo = idx_prod[36:24];
    quo_prod = {13'd0, idx_quo} * {13'd0, MODN};
    idx_rem = {1'b0, req.elem_index} - quo_prod[rmsp_pkg::IDX_W:0];
    idx_red = (idx_rem >= MODN) ? rmsp_pkg::IDX_W'(idx_rem - MODN) :
              idx_rem[rmsp_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        item.idx <= idx_red;
        item.gradient <= req.gradient;
        item.weight <= req.weight;
        item.learning_rate <= req.learning_rate;
        item_valid <= 1'b1;
      end else if (item_valid && item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/rmsp_queue.sv
`timescale 1ns / 1ps
module rmsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  rmsp_pkg::item_t push_data,
  input  logic            push_valid,
  output logic            push_ready,
  output rmsp_pkg::item_t pop_data,
  output logic            pop_valid,
  input  logic            pop_ready
);

  localparam int PW = rmsp_pkg::QUEUE_DEPTH > 1 ? $clog2(rmsp_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(rmsp_pkg::QUEUE_DEPTH + 1);

  rmsp_pkg::item_t slots [rmsp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(rmsp_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_data = slots[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(rmsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(rmsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### rtl/core/rmsp_back.sv
`timescale 1ns / 1ps
`include "rmsprop_element_update_unit_defines.svh"
module rmsp_back #(
  parameter int ELEMENT_COUNT = rmsp_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  rmsp_pkg::item_t                 item,
  input  logic                            item_valid,
  output logic                            item_ready,
  rmsp_out_if.source                      rsp
);

  localparam int DEPTH = ELEMENT_COUNT > rmsp_pkg::IDX_SPAN ?
                         rmsp_pkg::IDX_SPAN : ELEMENT_COUNT;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RD, S_DEC_M, S_DEC_A, S_SQ_M, S_SQ_A, S_V_M1, S_V_M2, S_V_A,
    S_C_M1, S_C_M2, S_C_A, S_C_SQM, S_C_SQA, S_RPREP, S_ROOT, S_DPREP, S_DIV, S_QUO,
    S_M_M, S_M_A, S_W_M, S_W_A
  } state_t;

  state_t             state;
  rmsp_pkg::cfg_t     cfg;
  rmsp_pkg::item_t    cur;
  logic signed [31:0] g;
  logic [31:0]        sq;
  logic signed [67:0] acc;
  logic signed [67:0] prod;
  logic [31:0]        var_r;
  logic [31:0]        sa_new;
  logic signed [31:0] m32;
  logic [47:0]        sx;
  logic [25:0]        rem;
  logic [23:0]        root;
  logic [24:0]        d;
  logic [47:0]        num;
  logic [47:0]        quo;
  logic [5:0]         cnt;
  logic signed [31:0] q;
  logic signed [31:0] step;
  logic               flag;
  logic [AW-1:0]      clr_addr;

  logic [31:0] sa_mem [DEPTH];
  logic [31:0] ga_mem [DEPTH];
  logic [31:0] mb_mem [DEPTH];
  logic [31:0] sa_q;
  logic [31:0] ga_q;
  logic [31:0] mb_q;

  logic signed [33:0] op_a;
  logic signed [33:0] op_b;
  logic               mul_en;
  logic [16:0]        rest;
  logic               out_free;
  logic               fin;
  logic               clearing;
  logic [AW-1:0]      wa;

  logic [32:0]        sat_dec;
  logic [32:0]        sat_m;
  logic [32:0]        sat_q;
  logic [32:0]        sat_b;
  logic [32:0]        sat_w;
  logic [67:0]        vsum;
  logic signed [51:0] msq;
  logic [27:0]        r_tr;
  logic [27:0]        trial;
  logic [25:0]        r2;
  logic [24:0]        d_c;
  logic [31:0]        mag;
  logic [32:0]        qmag;
  logic signed [67:0] qs;

  assign rest = rmsp_pkg::ONE_Q16 - {1'b0, cfg.smoothing_alpha};
  assign item_ready = state == S_IDLE;
  assign out_free = !rsp.valid || rsp.ready;
  assign fin = (state == S_W_A) && out_free;
  assign clearing = state == S_CLEAR;
  assign wa = clearing ? clr_addr : cur.idx[AW-1:0];

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    mul_en = 1'b1;
    case (state)
      S_DEC_M: begin
        op_a = {18'd0, cfg.decay_coeff};
        op_b = 34'(cur.weight);
      end
      S_SQ_M: begin
        op_a = 34'(g);
        op_b = 34'(g);
      end
      S_V_M1: begin
        op_a = {18'd0, cfg.smoothing_alpha};
        op_b = {2'd0, sa_q};
      end
      S_V_M2: begin
        op_a = {17'd0, rest};
        op_b = {2'd0, sq};
      end
      S_C_M1: begin
        op_a = {18'd0, cfg.smoothing_alpha};
        op_b = 34'($signed(ga_q));
      end
      S_C_M2: begin
        op_a = {17'd0, rest};
        op_b = 34'(g);
      end
      S_C_SQM: begin
        op_a = 34'(m32);
        op_b = 34'(m32);
      end
      S_M_M: begin
        op_a = {18'd0, cfg.momentum_coeff};
        op_b = 34'($signed(mb_q));
      end
      S_W_M: begin
        op_a = {18'd0, cur.learning_rate};
        op_b = 34'(step);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    sat_dec = rmsp_pkg::sat32(68'(g) + 68'(rmsp_pkg::rnd16(prod)));
    sat_m = rmsp_pkg::sat32(68'(rmsp_pkg::rnd16(acc + prod)));
    vsum = 68'(acc + prod + 68'sd32768) >> 16;
    msq = rmsp_pkg::rnd16(prod);
    r_tr = {rem, sx[47:46]};
    trial = {2'd0, root, 2'b01};
    r2 = {rem[24:0], num[47]};
    d_c = {1'b0, root} + {9'd0, cfg.epsilon};
    mag = 32'd0 - g;
    if (!g[31]) begin
      mag = g;
    end
    qmag = (quo > 48'h8000_0000) ? 33'h1_0000_0000 >> 1 : quo[32:0];
    qs = g[31] ? -68'(qmag) : 68'(qmag);
    sat_q = rmsp_pkg::sat32(qs);
    sat_b = rmsp_pkg::sat32(68'(rmsp_pkg::rnd16(prod)) + 68'(q));
    sat_w = rmsp_pkg::sat32(68'(cur.weight) - 68'(rmsp_pkg::rnd16(prod)));
  end

  // per-element state stores
  always_ff @(posedge clk) begin
    if (clearing || fin) begin
      sa_mem[wa] <= clearing ? 32'd0 : sa_new;
    end
    if (clearing || (fin && cfg.centered_mode)) begin
      ga_mem[wa] <= clearing ? 32'd0 : m32;
    end
    if (clearing || (fin && cfg.momentum_enable)) begin
      mb_mem[wa] <= clearing ? 32'd0 : step;
    end
    sa_q <= sa_mem[cur.idx[AW-1:0]];
    ga_q <= ga_mem[cur.idx[AW-1:0]];
    mb_q <= mb_mem[cur.idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      rsp.valid <= 1'b0;
      cfg.decay_enable <= 1'b0;
      cfg.decay_coeff <= '0;
      cfg.momentum_enable <= 1'b0;
      cfg.momentum_coeff <= '0;
      cfg.smoothing_alpha <= rmsp_pkg::ALPHA_RESET;
      cfg.epsilon <= rmsp_pkg::EPS_RESET;
      cfg.centered_mode <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (rmsp_pkg::cfg_idx_t'(cfg_index))
          rmsp_pkg::CFG_DECAY_EN:    cfg.decay_enable <= cfg_data[0];
          rmsp_pkg::CFG_DECAY_COEFF: cfg.decay_coeff <= cfg_data;
          rmsp_pkg::CFG_MOM_EN:      cfg.momentum_enable <= cfg_data[0];
          rmsp_pkg::CFG_MOM_COEFF:   cfg.momentum_coeff <= cfg_data;
          rmsp_pkg::CFG_ALPHA:       cfg.smoothing_alpha <= cfg_data;
          rmsp_pkg::CFG_EPSILON:     cfg.epsilon <= cfg_data;
          rmsp_pkg::CFG_CENTERED:    cfg.centered_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (fin) begin
        rsp.valid <= 1'b1;
        rsp.new_weight <= sat_w[31:0];
        rsp.saturated <= flag | sat_w[32];
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (mul_en) begin
        prod <= op_a * op_b;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            g <= item.gradient;
            flag <= 1'b0;
            state <= S_RD;
          end
        end
        S_RD:    state <= S_DEC_M;
        S_DEC_M: state <= S_DEC_A;
        S_DEC_A: begin
          if (cfg.decay_enable) begin
            g <= sat_dec[31:0];
            flag <= flag | sat_dec[32];
          end
          state <= S_SQ_M;
        end
        S_SQ_M:  state <= S_SQ_A;
        S_SQ_A: begin
          if (msq > 52'sh0_FFFF_FFFF) begin
            sq <= 32'hFFFF_FFFF;
            flag <= 1'b1;
          end else begin
            sq <= msq[31:0];
          end
          state <= S_V_M1;
        end
        S_V_M1:  state <= S_V_M2;
        S_V_M2: begin
          acc <= prod;
          state <= S_V_A;
        end
        S_V_A: begin
          var_r <= 32'(vsum);
          sa_new <= 32'(vsum);
          state <= cfg.centered_mode ? S_C_M1 : S_RPREP;
        end
        S_C_M1:  state <= S_C_M2;
        S_C_M2: begin
          acc <= prod;
          state <= S_C_A;
        end
        S_C_A: begin
          m32 <= sat_m[31:0];
          flag <= flag | sat_m[32];
          state <= S_C_SQM;
        end
        S_C_SQM: state <= S_C_SQA;
        S_C_SQA: begin
          if (msq > $signed({20'd0, var_r})) begin
            var_r <= '0;
            flag <= 1'b1;
          end else begin
            var_r <= var_r - msq[31:0];
          end
          state <= S_RPREP;
        end
        S_RPREP: begin
          sx <= {var_r, 16'd0};
          rem <= '0;
          root <= '0;
          cnt <= 6'd23;
          state <= S_ROOT;
        end
        // square root, two radicand bits a cycle
        S_ROOT: begin
          if (r_tr >= trial) begin
            rem <= 26'(r_tr - trial);
            root <= {root[22:0], 1'b1};
          end else begin
            rem <= 26'(r_tr);
            root <= {root[22:0], 1'b0};
          end
          sx <= sx << 2;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_DPREP;
          end
        end
        S_DPREP: begin
          d <= d_c;
          if (d_c == '0) begin
            if (g == 32'sd0) begin
              q <= '0;
              step <= '0;
            end else begin
              q <= g[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
              step <= g[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
              flag <= 1'b1;
            end
            state <= cfg.momentum_enable ? S_M_M : S_W_M;
          end else begin
            num <= {mag, 16'd0} + 48'(d_c >> 1);
            rem <= '0;
            quo <= '0;
            cnt <= 6'd47;
            state <= S_DIV;
          end
        end
        // long division, one quotient bit a cycle
        S_DIV: begin
          if (r2 >= {1'b0, d}) begin
            rem <= r2 - {1'b0, d};
            quo <= {quo[46:0], 1'b1};
          end else begin
            rem <= r2;
            quo <= {quo[46:0], 1'b0};
          end
          num <= num << 1;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_QUO;
          end
        end
        S_QUO: begin
          q <= sat_q[31:0];
          step <= sat_q[31:0];
          flag <= flag | sat_q[32];
          state <= cfg.momentum_enable ? S_M_M : S_W_M;
        end
        S_M_M:   state <= S_M_A;
        S_M_A: begin
          step <= sat_b[31:0];
          flag <= flag | sat_b[32];
          state <= S_W_M;
        end
        S_W_M:   state <= S_W_A;
        S_W_A: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RMSP_ASSERT_IMPL(a_div_nonzero, clk, rst, state == S_DIV, d != '0)
  `RMSP_ASSERT_NEXT(a_take_reads, clk, rst, item_valid && item_ready, state == S_RD)
  `RMSP_ASSERT_IMPL(a_root_count, clk, rst, state == S_ROOT, cnt <= 6'd23)

endmodule

### rtl/core/rmsprop_element_update_unit.sv
`timescale 1ns / 1ps
// RMSprop update for one Q16.16 parameter element per transaction, with per-element
// square average, gradient average and momentum buffer held in on-chip memories.
// After reset the back end clears min(ELEMENT_COUNT, 4096) entries of those memories
// before it takes an element; configuration writes are taken throughout. A front
// stage accepts the transaction and wraps the index into a register, a two-entry
// queue follows, and the back end processes one element at a time through a 24-step
// square root and a 48-step divider, with extra states in centered mode and with
// momentum; when root and epsilon are both zero the divider is skipped. Results
// leave through an output register.
module rmsprop_element_update_unit #(
  parameter int ELEMENT_COUNT = rmsp_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rmsp_in_if.sink                         req,
  rmsp_out_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [rmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmsp_pkg::CFG_DATA_W-1:0] cfg_data
);

  rmsp_pkg::item_t fr_item;
  logic            fr_valid;
  logic            fr_ready;
  rmsp_pkg::item_t bk_item;
  logic            bk_valid;
  logic            bk_ready;

  rmsp_front #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .item       (fr_item),
    .item_valid (fr_valid),
    .item_ready (fr_ready)
  );

  rmsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (fr_item),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .pop_data   (bk_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready)
  );

  rmsp_back #(.ELEMENT_COUNT(ELEMENT_COUNT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item       (bk_item),
    .item_valid (bk_valid),
    .item_ready (bk_ready),
    .rsp        (rsp)
  );

endmodule
